@@ sv/frwl_pkg.sv @@
// ----------------------------------------------------------------------------
// frwl_pkg
// shared types and codes for the fair reader-writer lock
// ----------------------------------------------------------------------------
`default_nettype none

package frwl_pkg;

  // results one command may cause at most
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NresWidth  = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_REQ_SHARED = 2'd0,
    CMD_REQ_EXCL   = 2'd1,
    CMD_REL_SHARED = 2'd2,
    CMD_REL_EXCL   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_GRANTED  = 3'd0,
    STAT_QUEUED   = 3'd1,
    STAT_WOKEN    = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_REL_ERR  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] requester_id;
  } frwl_req_t;

  typedef struct packed {
    logic [7:0] grantee_id;
    logic [2:0] status;
    logic       grant_exclusive;
    logic       last;
  } frwl_rsp_t;

endpackage

`default_nettype wire

@@ sv/fair_reader_writer_lock.sv @@
// ----------------------------------------------------------------------------
// fair_reader_writer_lock
// reader-writer lock with a first-in first-out wait queue held in a ram
// ----------------------------------------------------------------------------
// results: a request or release error gives its one result from the result register;
//   a promoted writer's result passes the wake state, then the result register; a reader
//   run passes the wake state, the pending and the result register, then one per cycle
// busy: only a release with waiters holds busy, blocking new commands while the wake
//   state wakes the head's reader run or promotes a writer; the receiver cannot stall
// reset: asynchronous, clears the queue pointers, counts and holder state
// ----------------------------------------------------------------------------
`default_nettype none

module fair_reader_writer_lock
  import frwl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8,
  parameter int unsigned MAX_READERS = 255
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire frwl_req_t item_i,
  output logic           busy_o,
  output logic           result_valid_o,
  output frwl_rsp_t      result_o
);

  localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RcWidth  = (MAX_READERS > 1) ? $clog2(MAX_READERS + 1) : 1;

  // one-hot sequencer: idle takes commands, wake walks the queue head
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAKE = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [PtrWidth-1:0]  head_q, head_d;
  logic [PtrWidth-1:0]  tail_q, tail_d;
  logic [CntWidth-1:0]  qcount_q, qcount_d;
  logic [RcWidth-1:0]   rcount_q, rcount_d;
  logic                 writer_held_q, writer_held_d;
  logic                 rel_excl_q, rel_excl_d;   // mode of the release in flight
  logic                 first_q, first_d;         // first head look of this release
  logic [NresWidth-1:0] nres_q, nres_d;           // results emitted by this release
  logic                 pend_valid_q, pend_valid_d;
  frwl_rsp_t            pend_q, pend_d;           // woken reader held until last is known
  logic                 out_valid_q, out_valid_d;
  frwl_rsp_t            out_q, out_d;

  // waiter ring: {is_writer, id}
  logic [ID_WIDTH:0]    ring_mem_q [QUEUE_DEPTH];
  logic [ID_WIDTH:0]    rd_data_q;
  logic [PtrWidth-1:0]  rd_addr;
  logic                 wr_en;
  logic [ID_WIDTH:0]    wr_data;

  logic                 accept;
  logic                 dequeue;
  logic [ID_WIDTH-1:0]  req_id;
  logic [PtrWidth-1:0]  head_inc;
  logic [PtrWidth-1:0]  tail_inc;
  logic                 queue_empty;
  logic                 queue_full;
  logic                 readers_full;
  logic                 head_writer;
  logic [7:0]           head_id;

  assign accept       = start_i && (state_q == ST_IDLE);
  assign req_id       = ID_WIDTH'(item_i.requester_id);
  assign head_inc     = (head_q == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc     = (tail_q == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign queue_empty  = (qcount_q == '0);
  assign queue_full   = (qcount_q == CntWidth'(QUEUE_DEPTH));
  assign readers_full = (rcount_q >= RcWidth'(MAX_READERS));
  assign head_writer  = rd_data_q[ID_WIDTH];
  assign head_id      = 8'(rd_data_q[ID_WIDTH-1:0]);

  // next head is read ahead so the wake loop sees the new head's entry in the cycle after the dequeue
  assign rd_addr = dequeue ? head_inc : head_q;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    qcount_d      = qcount_q;
    rcount_d      = rcount_q;
    writer_held_d = writer_held_q;
    rel_excl_d    = rel_excl_q;
    first_d       = first_q;
    nres_d        = nres_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    out_valid_d   = 1'b0;
    out_d         = out_q;
    wr_en         = 1'b0;
    wr_data       = {1'b0, req_id};
    dequeue       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d          = 1'b1;
          out_d.grantee_id     = 8'(req_id);
          out_d.last           = 1'b1;
          out_d.grant_exclusive = item_i.cmd[0];
          case (item_i.cmd)
            CMD_REQ_SHARED: begin
              if (!writer_held_q && queue_empty) begin
                if (readers_full) begin
                  out_d.status = STAT_REJECTED;
                end else begin
                  rcount_d     = rcount_q + 1'b1;
                  out_d.status = STAT_GRANTED;
                end
              end else if (queue_full) begin
                out_d.status = STAT_REJECTED;
              end else begin
                wr_en        = 1'b1;
                wr_data      = {1'b0, req_id};
                tail_d       = tail_inc;
                qcount_d     = qcount_q + 1'b1;
                out_d.status = STAT_QUEUED;
              end
            end
            CMD_REQ_EXCL: begin
              if (!writer_held_q && rcount_q == '0 && queue_empty) begin
                writer_held_d = 1'b1;
                out_d.status  = STAT_GRANTED;
              end else if (queue_full) begin
                out_d.status = STAT_REJECTED;
              end else begin
                wr_en        = 1'b1;
                wr_data      = {1'b1, req_id};
                tail_d       = tail_inc;
                qcount_d     = qcount_q + 1'b1;
                out_d.status = STAT_QUEUED;
              end
            end
            CMD_REL_SHARED: begin
              if (writer_held_q || rcount_q == '0) begin
                out_d.status = STAT_REL_ERR;
              end else begin
                out_valid_d = 1'b0;
                rcount_d    = rcount_q - 1'b1;
                if (!queue_empty) begin
                  state_d    = ST_WAKE;
                  rel_excl_d = 1'b0;
                  first_d    = 1'b1;
                  nres_d     = '0;
                end
              end
            end
            default: begin
              if (!writer_held_q) begin
                out_d.status = STAT_REL_ERR;
              end else begin
                out_valid_d   = 1'b0;
                writer_held_d = 1'b0;
                if (!queue_empty) begin
                  state_d    = ST_WAKE;
                  rel_excl_d = 1'b1;
                  first_d    = 1'b1;
                  nres_d     = '0;
                end
              end
            end
          endcase
        end
      end
      ST_WAKE: begin
        first_d = 1'b0;
        if (!queue_empty && head_writer && first_q &&
            (rel_excl_q || rcount_q == '0)) begin
          // promote one writer, always a lone result
          dequeue               = 1'b1;
          head_d                = head_inc;
          qcount_d              = qcount_q - 1'b1;
          writer_held_d         = 1'b1;
          out_valid_d           = 1'b1;
          out_d.grantee_id      = head_id;
          out_d.status          = STAT_WOKEN;
          out_d.grant_exclusive = 1'b1;
          out_d.last            = 1'b1;
          state_d               = ST_IDLE;
        end else if (!queue_empty && !head_writer && !readers_full &&
                     nres_q < NresWidth'(MaxResults)) begin
          // wake one reader of the run at the head
          dequeue                = 1'b1;
          head_d                 = head_inc;
          qcount_d               = qcount_q - 1'b1;
          rcount_d               = rcount_q + 1'b1;
          nres_d                 = nres_q + 1'b1;
          pend_valid_d           = 1'b1;
          pend_d.grantee_id      = head_id;
          pend_d.status          = STAT_WOKEN;
          pend_d.grant_exclusive = 1'b0;
          pend_d.last            = 1'b0;
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_d.last  = 1'b0;
          end
        end else begin
          // run ends: the held reader, if any, is the final result
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_d.last  = 1'b1;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d      = ST_IDLE;
        pend_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      qcount_q      <= '0;
      rcount_q      <= '0;
      writer_held_q <= 1'b0;
      rel_excl_q    <= 1'b0;
      first_q       <= 1'b0;
      nres_q        <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      qcount_q      <= qcount_d;
      rcount_q      <= rcount_d;
      writer_held_q <= writer_held_d;
      rel_excl_q    <= rel_excl_d;
      first_q       <= first_d;
      nres_q        <= nres_d;
      pend_valid_q  <= pend_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // waiter ring ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem_q[tail_q] <= wr_data;
    end
    rd_data_q <= ring_mem_q[rd_addr];
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

`ifndef SYNTHESIS
  // a writer never shares the lock with readers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(writer_held_q && rcount_q != '0))
    else $error("writer held while readers hold the lock");

  // a held wake result only exists while the queue walk runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_WAKE))
    else $error("pending result outside wake walk");

  // the ram is never written during a wake walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAKE) |-> !wr_en)
    else $error("ring write during wake walk");

  // one release never yields more results than allowed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NresWidth'(MaxResults))
    else $error("too many results for one release");

  // queue count stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= CntWidth'(QUEUE_DEPTH))
    else $error("queue count overflow");
`endif

endmodule

`default_nettype wire
